// ----- sv/logit_penalty_argmax_picker_assert.svh -----
// Assertion macros for the picker RTL
`ifndef LOGIT_PENALTY_ARGMAX_PICKER_ASSERT_SVH
`define LOGIT_PENALTY_ARGMAX_PICKER_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define LPAP_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence must hold in the same cycle as the antecedent
`define LPAP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence must hold in the cycle after the antecedent
`define LPAP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/lpap_pkg.sv -----
// Types, constants and helpers shared by the picker modules
package lpap_pkg;

   localparam int ID_W       = 23;
   localparam int HENT_W     = 24;
   localparam int LOGIT_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_TRACE_STRENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACE_WINDOW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACE_DECAY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_PENALTY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NGRAM_SIZE     = 3'd4;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_EMPTY   = 2'd1;
   localparam logic [1:0] STAT_DROPPED = 2'd2;

   localparam logic [ID_W-1:0] ID_LIMIT   = 23'd8000000;
   localparam logic [31:0]     WT_ONE     = 32'd65536;
   localparam logic [23:0]     RP_ONE     = 24'd65536;
   localparam logic [17:0]     DECAY_ONE  = 18'd65536;

   typedef enum logic [4:0] {
      S_LOAD, S_CHECK, S_CLR,
      S_TR_INIT, S_TR_RD, S_TR_MUL, S_TR_UPD,
      S_PN_INIT, S_PN_RD, S_PN_CHK, S_PN_MUL, S_PN_DIV, S_PN_WR,
      S_NG_INIT, S_NG_CMP_RD, S_NG_CMP, S_NG_NX_RD, S_NG_NX, S_NG_ADV,
      S_AM_INIT, S_AM, S_AM_END, S_OUT
   } lpap_state_type;

   typedef enum logic [4:0] {
      OP_LOAD, OP_CLR_INIT, OP_CLR,
      OP_TR_INIT, OP_TR_RD, OP_TR_MUL, OP_TR_UPD,
      OP_PN_INIT, OP_PN_RD, OP_PN_CHK, OP_PN_MUL, OP_PN_DIV, OP_PN_WR,
      OP_NG_INIT, OP_NG_CMP_RD, OP_NG_CMP, OP_NG_NX_RD, OP_NG_NX, OP_NG_ADV,
      OP_AM_INIT, OP_AM, OP_AM_END, OP_OUT
   } lpap_op_type;

   typedef struct packed {
      lpap_op_type op;
   } lpap_cmd_type;

   typedef struct packed {
      logic last_in;
      logic empty;
      logic clr_last;
      logic tr_en;
      logic tr_last;
      logic pn_en;
      logic pn_last;
      logic pn_skip;
      logic pn_pos;
      logic div_done;
      logic ng_en;
      logic ng_p0;
      logic ng_miss;
      logic ng_k_last;
      logic ng_i_last;
      logic am_last;
      logic out_free;
   } lpap_stat_type;

   function automatic logic [31:0] sat32(input logic signed [64:0] x);
      logic [31:0] r;
      if (x > 65'sd2147483647) r = 32'h7FFF_FFFF;
      else if (x < -65'sd2147483648) r = 32'h8000_0000;
      else r = x[31:0];
      return r;
   endfunction

endpackage

// ----- sv/lpap_req_if.sv -----
// Request channel: logit and history items
interface lpap_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [31:0] logit_value;
   logic [22:0]        history_token;
   logic               history_valid;
   logic               last;

   modport source(output valid, kind, logit_value, history_token, history_valid, last,
                  input ready);
   modport sink(input valid, kind, logit_value, history_token, history_valid, last,
                output ready);
endinterface

// ----- sv/lpap_rsp_if.sv -----
// Result channel: chosen token and status
interface lpap_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] chosen_token;
   logic [1:0]  status;

   modport source(output valid, chosen_token, status, input ready);
   modport sink(input valid, chosen_token, status, output ready);
endinterface

// ----- sv/logit_penalty_argmax_picker.sv -----
// Top level: greedy token picker with recency trace, repetition penalty and n-gram ban
// Load items (logits in index order, history ids in arrival order) are taken one
// per cycle. The item marked last starts the passes, during which no item is
// taken: a clear sweep of the seen and banned marks, the recency trace over the
// windowed ids, the penalty over the history ids (with a write-back of each
// changed logit, and a pass through the bit-serial divider for a positive
// logit), the n-gram ban over each start position and the argmax, plus setup
// steps; the passes share the single read port of the logit memory.
// The result then sits in an output register until taken, and loading of the
// next request resumes as soon as it is written.
module logit_penalty_argmax_picker import lpap_pkg::*; #(
   parameter int MAX_VOCAB   = 65536,
   parameter int MAX_HISTORY = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   lpap_req_if.sink              req_ch,
   lpap_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   lpap_cmd_type  cmd;
   lpap_stat_type stat;

   lpap_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .stat (stat),
      .cmd  (cmd)
   );

   lpap_datapath #(
      .MAX_VOCAB  (MAX_VOCAB),
      .MAX_HISTORY(MAX_HISTORY)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );
endmodule

// ----- sv/lpap_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module lpap_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

// ----- sv/lpap_ctrl.sv -----
// Sequencer for load, clear, trace, penalty, n-gram ban and argmax phases
module lpap_ctrl import lpap_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  lpap_stat_type stat,
   output lpap_cmd_type  cmd
);
   lpap_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_LOAD;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_LOAD:      if (stat.last_in) state_in = S_CHECK;
         S_CHECK:     state_in = stat.empty ? S_OUT : S_CLR;
         S_CLR:       if (stat.clr_last) state_in = S_TR_INIT;
         S_TR_INIT:   state_in = stat.tr_en ? S_TR_RD : S_PN_INIT;
         S_TR_RD:     state_in = S_TR_MUL;
         S_TR_MUL:    state_in = S_TR_UPD;
         S_TR_UPD:    state_in = stat.tr_last ? S_PN_INIT : S_TR_RD;
         S_PN_INIT:   state_in = stat.pn_en ? S_PN_RD : S_NG_INIT;
         S_PN_RD:     state_in = S_PN_CHK;
         S_PN_CHK:    state_in = S_PN_MUL;
         S_PN_MUL: begin
            if (stat.pn_skip) state_in = stat.pn_last ? S_NG_INIT : S_PN_RD;
            else state_in = stat.pn_pos ? S_PN_DIV : S_PN_WR;
         end
         S_PN_DIV:    if (stat.div_done) state_in = S_PN_WR;
         S_PN_WR:     state_in = stat.pn_last ? S_NG_INIT : S_PN_RD;
         S_NG_INIT: begin
            if (!stat.ng_en) state_in = S_AM_INIT;
            else state_in = stat.ng_p0 ? S_NG_NX_RD : S_NG_CMP_RD;
         end
         S_NG_CMP_RD: state_in = S_NG_CMP;
         S_NG_CMP: begin
            if (stat.ng_miss) state_in = S_NG_ADV;
            else state_in = stat.ng_k_last ? S_NG_NX_RD : S_NG_CMP_RD;
         end
         S_NG_NX_RD:  state_in = S_NG_NX;
         S_NG_NX:     state_in = S_NG_ADV;
         S_NG_ADV: begin
            if (stat.ng_i_last) state_in = S_AM_INIT;
            else state_in = stat.ng_p0 ? S_NG_NX_RD : S_NG_CMP_RD;
         end
         S_AM_INIT:   state_in = S_AM;
         S_AM:        if (stat.am_last) state_in = S_AM_END;
         S_AM_END:    state_in = S_OUT;
         S_OUT:       if (stat.out_free) state_in = S_LOAD;
         default:     state_in = S_LOAD;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         S_LOAD:      cmd.op = OP_LOAD;
         S_CHECK:     cmd.op = OP_CLR_INIT;
         S_CLR:       cmd.op = OP_CLR;
         S_TR_INIT:   cmd.op = OP_TR_INIT;
         S_TR_RD:     cmd.op = OP_TR_RD;
         S_TR_MUL:    cmd.op = OP_TR_MUL;
         S_TR_UPD:    cmd.op = OP_TR_UPD;
         S_PN_INIT:   cmd.op = OP_PN_INIT;
         S_PN_RD:     cmd.op = OP_PN_RD;
         S_PN_CHK:    cmd.op = OP_PN_CHK;
         S_PN_MUL:    cmd.op = OP_PN_MUL;
         S_PN_DIV:    cmd.op = OP_PN_DIV;
         S_PN_WR:     cmd.op = OP_PN_WR;
         S_NG_INIT:   cmd.op = OP_NG_INIT;
         S_NG_CMP_RD: cmd.op = OP_NG_CMP_RD;
         S_NG_CMP:    cmd.op = OP_NG_CMP;
         S_NG_NX_RD:  cmd.op = OP_NG_NX_RD;
         S_NG_NX:     cmd.op = OP_NG_NX;
         S_NG_ADV:    cmd.op = OP_NG_ADV;
         S_AM_INIT:   cmd.op = OP_AM_INIT;
         S_AM:        cmd.op = OP_AM;
         S_AM_END:    cmd.op = OP_AM_END;
         S_OUT:       cmd.op = OP_OUT;
         default:     cmd.op = OP_LOAD;
      endcase
   end
endmodule

// ----- sv/lpap_datapath.sv -----
// Stores, counters, arithmetic units and result register of the picker
`include "logit_penalty_argmax_picker_assert.svh"
module lpap_datapath import lpap_pkg::*; #(
   parameter int MAX_VOCAB   = 65536,
   parameter int MAX_HISTORY = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lpap_cmd_type          cmd,
   output lpap_stat_type         stat,
   lpap_req_if.sink              req_ch,
   lpap_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int VCW = $clog2(MAX_VOCAB + 1);
   localparam int VAW = $clog2(MAX_VOCAB);
   localparam int HCW = $clog2(MAX_HISTORY + 1);
   localparam int HAW = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
   localparam int CW  = (HCW > 11) ? HCW : 11;

   // configuration
   logic signed [31:0] strength_ff, strength_in;
   logic [10:0]        window_ff, window_in;
   logic [17:0]        decay_ff, decay_in;
   logic [23:0]        rp_ff, rp_in;
   logic [10:0]        ng_ff, ng_in;

   // request bookkeeping
   logic [VCW-1:0] vcount_ff, vcount_in;
   logic [HCW-1:0] hcount_ff, hcount_in;
   logic           allv_ff, allv_in;
   logic           drop_ff, drop_in;

   // pass counters and working registers
   logic [VAW-1:0]     idx_ff, idx_in;
   logic [HCW-1:0]     hk_ff, hk_in;
   logic [10:0]        gk_ff, gk_in;
   logic [31:0]        wt_ff, wt_in;
   logic signed [64:0] prod_ff, prod_in;
   logic [49:0]        wprod_ff, wprod_in;
   logic signed [56:0] nprod_ff, nprod_in;
   logic [VAW-1:0]     t_ff, t_in;
   logic               ok_ff, ok_in;
   logic               pos_ff, pos_in;
   logic [47:0]        num_ff, num_in;
   logic [23:0]        rem_ff, rem_in;
   logic [5:0]         dcnt_ff, dcnt_in;
   logic signed [31:0] best_val_ff, best_val_in;
   logic [VAW-1:0]     best_idx_ff, best_idx_in;
   logic               have_ff, have_in;
   logic               amv_ff, amv_in;
   logic [VAW-1:0]     amidx_ff, amidx_in;

   // result register
   logic        rvalid_ff, rvalid_in;
   logic [15:0] rtok_ff, rtok_in;
   logic [1:0]  rstat_ff, rstat_in;

   // memory ports
   logic               lg_we, hs_we, sn_we, bn_we, sn_wd, bn_wd;
   logic [VAW-1:0]     lg_wa, lg_ra, sn_wa, sn_ra, bn_wa, bn_ra;
   logic [31:0]        lg_wd, lg_rd;
   logic [HAW-1:0]     hs_wa, ha_ra, hb_ra;
   logic [HENT_W-1:0]  hs_wd, ha_rd, hb_rd;
   logic               sn_rd, bn_rd;

   logic               fire, vroom, hroom, tok_ok, ha_ok, nx_ok, out_free, am_hit;
   logic [CW-1:0]      len_c, win_c, n_c, hk_c, ng_c, p_c;
   logic [CW:0]        i_end;
   logic signed [31:0] lrd;
   logic [31:0]        tr_new, pn_q, pn_new;
   logic signed [64:0] nwide;
   logic [50:0]        wsum;
   logic [24:0]        rsh;
   logic [VAW+15:0]    bidx_ext;

   lpap_ram #(.WIDTH(32), .DEPTH(MAX_VOCAB)) u_logit (
      .clock(clock), .we(lg_we), .waddr(lg_wa), .wdata(lg_wd), .raddr(lg_ra), .rdata(lg_rd));
   lpap_ram #(.WIDTH(1), .DEPTH(MAX_VOCAB)) u_seen (
      .clock(clock), .we(sn_we), .waddr(sn_wa), .wdata(sn_wd), .raddr(sn_ra), .rdata(sn_rd));
   lpap_ram #(.WIDTH(1), .DEPTH(MAX_VOCAB)) u_banned (
      .clock(clock), .we(bn_we), .waddr(bn_wa), .wdata(bn_wd), .raddr(bn_ra), .rdata(bn_rd));
   // two copies of the history so the n-gram compare reads both sides at once
   lpap_ram #(.WIDTH(HENT_W), .DEPTH(MAX_HISTORY)) u_hist_a (
      .clock(clock), .we(hs_we), .waddr(hs_wa), .wdata(hs_wd), .raddr(ha_ra), .rdata(ha_rd));
   lpap_ram #(.WIDTH(HENT_W), .DEPTH(MAX_HISTORY)) u_hist_b (
      .clock(clock), .we(hs_we), .waddr(hs_wa), .wdata(hs_wd), .raddr(hb_ra), .rdata(hb_rd));

   assign req_ch.ready = (cmd.op == OP_LOAD);
   assign fire      = req_ch.valid && req_ch.ready;
   assign vroom     = vcount_ff < VCW'(MAX_VOCAB);
   assign hroom     = hcount_ff < HCW'(MAX_HISTORY);
   assign tok_ok    = req_ch.history_valid && (req_ch.history_token <= ID_LIMIT);
   assign lrd       = lg_rd;
   assign ha_ok     = ha_rd[ID_W] && ({1'b0, ha_rd[ID_W-1:0]} < 24'(vcount_ff));
   assign nx_ok     = {1'b0, ha_rd[ID_W-1:0]} < 24'(vcount_ff);
   assign out_free  = !rvalid_ff || rsp_ch.ready;

   assign len_c = CW'(hcount_ff);
   assign win_c = CW'(window_ff);
   assign n_c   = (len_c < win_c) ? len_c : win_c;
   assign hk_c  = CW'(hk_ff);
   assign ng_c  = CW'(ng_ff);
   assign p_c   = ng_c - CW'(1);
   assign i_end = {1'b0, hk_c} + {1'b0, ng_c};

   // trace: logit minus round(strength * weight)
   assign tr_new = sat32(65'(lrd) - ((prod_ff + 65'sd32768) >>> 16));
   assign wsum   = {1'b0, wprod_ff} + 51'd32768;
   assign nwide  = 65'(nprod_ff);
   assign pn_q   = (num_ff[47:31] != 17'd0) ? 32'h7FFF_FFFF : num_ff[31:0];
   assign pn_new = pos_ff ? pn_q : sat32((nwide + 65'sd32768) >>> 16);
   assign rsh    = {rem_ff, num_ff[47]};
   assign am_hit = amv_ff && !bn_rd && (!have_ff || (lrd > best_val_ff));
   assign bidx_ext = {16'd0, best_idx_ff};

   always_comb begin
      stat.last_in   = fire && req_ch.last;
      stat.empty     = (vcount_ff == VCW'(0));
      stat.clr_last  = (idx_ff == VAW'(vcount_ff - VCW'(1)));
      stat.tr_en     = (strength_ff != 32'sd0) && (len_c != CW'(0)) && (win_c != CW'(0));
      stat.tr_last   = (hk_c == n_c - CW'(1));
      stat.pn_en     = (rp_ff != 24'd0) && (rp_ff != RP_ONE) && (len_c != CW'(0));
      stat.pn_last   = (hk_c == len_c - CW'(1));
      stat.pn_skip   = !ok_ff || sn_rd;
      stat.pn_pos    = (lrd > 32'sd0);
      stat.div_done  = (dcnt_ff == 6'd47);
      stat.ng_en     = (ng_ff != 11'd0) && (len_c >= ng_c) && allv_ff;
      stat.ng_p0     = (ng_ff == 11'd1);
      stat.ng_miss   = (ha_rd[ID_W-1:0] != hb_rd[ID_W-1:0]);
      stat.ng_k_last = ((gk_ff + 11'd1) == (ng_ff - 11'd1));
      stat.ng_i_last = (i_end == {1'b0, len_c});
      stat.am_last   = stat.clr_last;
      stat.out_free  = out_free;
   end

   // memory port selection
   always_comb begin
      lg_we = 1'b0;  lg_wa = t_ff;  lg_wd = tr_new;  lg_ra = idx_ff;
      hs_we = 1'b0;  hs_wa = HAW'(hcount_ff);
      hs_wd = {tok_ok, req_ch.history_token};
      ha_ra = HAW'(hk_c);  hb_ra = HAW'(len_c - p_c + CW'(gk_ff));
      sn_we = 1'b0;  sn_wa = idx_ff;  sn_wd = 1'b0;  sn_ra = VAW'(ha_rd[ID_W-1:0]);
      bn_we = 1'b0;  bn_wa = idx_ff;  bn_wd = 1'b0;  bn_ra = idx_ff;
      case (cmd.op)
         OP_LOAD: begin
            lg_we = fire && !req_ch.kind && vroom;
            lg_wa = VAW'(vcount_ff);
            lg_wd = req_ch.logit_value;
            hs_we = fire && req_ch.kind && hroom;
         end
         OP_CLR: begin
            sn_we = 1'b1;
            bn_we = 1'b1;
         end
         OP_TR_RD:     ha_ra = HAW'(len_c - CW'(1) - hk_c);
         OP_TR_MUL:    lg_ra = VAW'(ha_rd[ID_W-1:0]);
         OP_TR_UPD:    lg_we = ok_ff;
         OP_PN_CHK:    lg_ra = VAW'(ha_rd[ID_W-1:0]);
         OP_PN_MUL: begin
            sn_we = !stat.pn_skip;
            sn_wa = t_ff;
            sn_wd = 1'b1;
         end
         OP_PN_WR: begin
            lg_we = 1'b1;
            lg_wd = pn_new;
         end
         OP_NG_CMP_RD: ha_ra = HAW'(hk_c + CW'(gk_ff));
         OP_NG_NX_RD:  ha_ra = HAW'(hk_c + p_c);
         OP_NG_NX: begin
            bn_we = nx_ok;
            bn_wa = VAW'(ha_rd[ID_W-1:0]);
            bn_wd = 1'b1;
         end
         default: ;
      endcase
   end

   // next-state of all datapath registers
   always_comb begin
      strength_in = strength_ff;  window_in = window_ff;  decay_in = decay_ff;
      rp_in = rp_ff;  ng_in = ng_ff;
      vcount_in = vcount_ff;  hcount_in = hcount_ff;  allv_in = allv_ff;  drop_in = drop_ff;
      idx_in = idx_ff;  hk_in = hk_ff;  gk_in = gk_ff;  wt_in = wt_ff;
      prod_in = prod_ff;  wprod_in = wprod_ff;  nprod_in = nprod_ff;
      t_in = t_ff;  ok_in = ok_ff;  pos_in = pos_ff;
      num_in = num_ff;  rem_in = rem_ff;  dcnt_in = dcnt_ff;
      best_val_in = best_val_ff;  best_idx_in = best_idx_ff;  have_in = have_ff;
      amv_in = amv_ff;  amidx_in = amidx_ff;
      rvalid_in = rvalid_ff && !rsp_ch.ready;
      rtok_in = rtok_ff;  rstat_in = rstat_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_TRACE_STRENGTH: strength_in = csr_wdata;
            CSR_TRACE_WINDOW:   window_in   = csr_wdata[10:0];
            CSR_TRACE_DECAY:    decay_in    = csr_wdata[17:0];
            CSR_REPEAT_PENALTY: rp_in       = csr_wdata[23:0];
            CSR_NGRAM_SIZE:     ng_in       = csr_wdata[10:0];
            default: ;
         endcase
      end

      case (cmd.op)
         OP_LOAD: begin
            if (fire) begin
               if (!req_ch.kind) begin
                  if (vroom) vcount_in = vcount_ff + VCW'(1);
                  else drop_in = 1'b1;
               end else begin
                  if (hroom) begin
                     hcount_in = hcount_ff + HCW'(1);
                     if (!tok_ok) allv_in = 1'b0;
                  end else drop_in = 1'b1;
               end
            end
         end
         OP_CLR_INIT: idx_in = '0;
         OP_CLR:      idx_in = idx_ff + VAW'(1);
         OP_TR_INIT: begin
            hk_in = '0;
            wt_in = WT_ONE;
         end
         OP_TR_MUL: begin
            t_in     = VAW'(ha_rd[ID_W-1:0]);
            ok_in    = ha_ok;
            prod_in  = strength_ff * $signed({1'b0, wt_ff});
            wprod_in = wt_ff * decay_ff;
         end
         OP_TR_UPD: begin
            wt_in = (wsum[50:48] != 3'd0) ? 32'hFFFF_FFFF : wsum[47:16];
            hk_in = hk_ff + HCW'(1);
         end
         OP_PN_INIT: hk_in = '0;
         OP_PN_CHK: begin
            t_in  = VAW'(ha_rd[ID_W-1:0]);
            ok_in = ha_ok;
         end
         OP_PN_MUL: begin
            if (stat.pn_skip) hk_in = hk_ff + HCW'(1);
            pos_in   = stat.pn_pos;
            nprod_in = lrd * $signed({1'b0, rp_ff});
            // (l * 65536 + p / 2) goes through the bit-serial divider
            num_in   = {1'b0, lrd[30:0], 16'd0} + 48'(rp_ff[23:1]);
            rem_in   = '0;
            dcnt_in  = '0;
         end
         OP_PN_DIV: begin
            if (rsh >= {1'b0, rp_ff}) begin
               rem_in = 24'(rsh - {1'b0, rp_ff});
               num_in = {num_ff[46:0], 1'b1};
            end else begin
               rem_in = rsh[23:0];
               num_in = {num_ff[46:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 6'd1;
         end
         OP_PN_WR: hk_in = hk_ff + HCW'(1);
         OP_NG_INIT: begin
            hk_in = '0;
            gk_in = '0;
         end
         OP_NG_CMP: if (!stat.ng_miss) gk_in = gk_ff + 11'd1;
         OP_NG_ADV: begin
            hk_in = hk_ff + HCW'(1);
            gk_in = '0;
         end
         OP_AM_INIT: begin
            idx_in      = '0;
            have_in     = 1'b0;
            best_val_in = '0;
            best_idx_in = '0;
            amv_in      = 1'b0;
         end
         OP_AM, OP_AM_END: begin
            amv_in   = (cmd.op == OP_AM);
            amidx_in = idx_ff;
            idx_in   = idx_ff + VAW'(1);
            if (am_hit) begin
               have_in     = 1'b1;
               best_val_in = lrd;
               best_idx_in = amidx_ff;
            end
         end
         OP_OUT: begin
            if (out_free) begin
               rvalid_in = 1'b1;
               if (vcount_ff == VCW'(0)) begin
                  rtok_in  = '0;
                  rstat_in = STAT_EMPTY;
               end else begin
                  rtok_in  = bidx_ext[15:0];
                  rstat_in = drop_ff ? STAT_DROPPED : STAT_OK;
               end
               vcount_in = '0;
               hcount_in = '0;
               allv_in   = 1'b1;
               drop_in   = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff <= '0;
         window_ff   <= '0;
         decay_ff    <= DECAY_ONE;
         rp_ff       <= RP_ONE;
         ng_ff       <= '0;
         vcount_ff   <= '0;
         hcount_ff   <= '0;
         allv_ff     <= 1'b1;
         drop_ff     <= 1'b0;
         best_val_ff <= '0;
         best_idx_ff <= '0;
         have_ff     <= 1'b0;
         amv_ff      <= 1'b0;
         rvalid_ff   <= 1'b0;
      end else begin
         strength_ff <= strength_in;
         window_ff   <= window_in;
         decay_ff    <= decay_in;
         rp_ff       <= rp_in;
         ng_ff       <= ng_in;
         vcount_ff   <= vcount_in;
         hcount_ff   <= hcount_in;
         allv_ff     <= allv_in;
         drop_ff     <= drop_in;
         best_val_ff <= best_val_in;
         best_idx_ff <= best_idx_in;
         have_ff     <= have_in;
         amv_ff      <= amv_in;
         rvalid_ff   <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      hk_ff    <= hk_in;
      gk_ff    <= gk_in;
      wt_ff    <= wt_in;
      prod_ff  <= prod_in;
      wprod_ff <= wprod_in;
      nprod_ff <= nprod_in;
      t_ff     <= t_in;
      ok_ff    <= ok_in;
      pos_ff   <= pos_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      dcnt_ff  <= dcnt_in;
      amidx_ff <= amidx_in;
      rtok_ff  <= rtok_in;
      rstat_ff <= rstat_in;
   end

   assign rsp_ch.valid        = rvalid_ff;
   assign rsp_ch.chosen_token = rtok_ff;
   assign rsp_ch.status       = rstat_ff;

   `LPAP_ASSERT_ALWAYS(a_vcount_bound, clock, reset, vcount_ff <= VCW'(MAX_VOCAB), "vocab count past store depth")
   `LPAP_ASSERT_ALWAYS(a_hcount_bound, clock, reset, hcount_ff <= HCW'(MAX_HISTORY), "history count past store depth")
   `LPAP_ASSERT_NXT(a_last_stops_load, clock, reset, req_ch.valid && req_ch.ready && req_ch.last, !req_ch.ready, "item taken right after closing item")
   `LPAP_ASSERT_IMP(a_result_from_out, clock, reset, $rose(rvalid_ff), $past(cmd.op == OP_OUT), "result raised outside output step")
endmodule

// ----- verif/logit_penalty_argmax_picker_tb.sv -----
// Testbench for the logit picker: directed table, then random requests checked by a predictor
module logit_penalty_argmax_picker_tb;
   import lpap_pkg::*;

   typedef struct {
      bit          kind;
      logic [31:0] lv;
      logic [22:0] tok;
      bit          hv;
      bit          last;
   } pick_item_type;

   typedef struct {
      pick_item_type it;
      bit            typed;
      logic [15:0]   etok;
      logic [1:0]    estat;
   } pick_row_type;

   typedef struct {
      logic [15:0] tok;
      logic [1:0]  stat;
   } pick_res_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   lpap_req_if req_ch();
   lpap_rsp_if rsp_ch();

   logit_penalty_argmax_picker u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   int          logit_mem [65536];
   bit          seen_mark [65536];
   bit          ban_mark  [65536];
   logic [23:0] hist_mem  [1024];
   int unsigned vcnt, hcnt;
   bit          all_valid, lost;
   int          cfg_strength;
   int unsigned cfg_window, cfg_decay, cfg_penalty, cfg_ngram;

   pick_res_type pick_q[$];
   int           errors = 0;
   bit           quiet = 1'b0;
   int           stall_left = 0;

   function automatic logic signed [95:0] rnd16(input logic signed [95:0] p);
      logic signed [95:0] q;
      q = p + 96'sd32768;
      if (q >= 0) return q / 96'sd65536;
      return -((-q + 96'sd65535) / 96'sd65536);
   endfunction

   function automatic int clamp32(input logic signed [95:0] x);
      if (x > 96'sd2147483647) return 32'h7FFF_FFFF;
      if (x < -96'sd2147483648) return 32'h8000_0000;
      return int'(x[31:0]);
   endfunction

   function automatic bit id_usable(input logic [23:0] e, input int unsigned v);
      return e[23] && (e[22:0] < v);
   endfunction

   function automatic pick_res_type pick_token();
      int unsigned v, len, n, p, t, nx;
      longint unsigned wt;
      logic signed [95:0] d, l, rp;
      bit same, have;
      int best;
      int unsigned idx;
      pick_res_type r;
      v = vcnt;
      len = hcnt;
      for (int unsigned i = 0; i < v; i++) begin
         seen_mark[i] = 0;
         ban_mark[i] = 0;
      end
      if (cfg_strength != 0 && len > 0) begin
         n = len < cfg_window ? len : cfg_window;
         wt = 65536;
         for (int unsigned k = 0; k < n; k++) begin
            if (id_usable(hist_mem[len-1-k], v)) begin
               t = hist_mem[len-1-k][22:0];
               d = rnd16(96'(signed'(cfg_strength)) * $signed({32'd0, wt}));
               logit_mem[t] = clamp32(96'(signed'(logit_mem[t])) - d);
            end
            wt = (wt * cfg_decay + 32768) >> 16;
            if (wt > 64'hFFFF_FFFF) wt = 64'hFFFF_FFFF;
         end
      end
      if (cfg_penalty != 0 && cfg_penalty != 65536 && len > 0) begin
         rp = $signed({64'd0, cfg_penalty});
         for (int unsigned i = 0; i < len; i++) begin
            t = hist_mem[i][22:0];
            if (id_usable(hist_mem[i], v) && !seen_mark[t]) begin
               seen_mark[t] = 1;
               l = 96'(signed'(logit_mem[t]));
               if (l > 0) logit_mem[t] = clamp32((l * 96'sd65536 + rp / 96'sd2) / rp);
               else logit_mem[t] = clamp32(rnd16(l * rp));
            end
         end
      end
      if (cfg_ngram > 0 && len > 0 && len >= cfg_ngram && all_valid) begin
         n = cfg_ngram;
         p = n - 1;
         for (int unsigned i = 0; i + n <= len; i++) begin
            same = 1;
            for (int unsigned k = 0; k < p && same; k++)
               if (hist_mem[i+k][22:0] != hist_mem[len-p+k][22:0]) same = 0;
            nx = hist_mem[i+p][22:0];
            if (same && nx < v) ban_mark[nx] = 1;
         end
      end
      have = 0;
      best = 0;
      idx = 0;
      for (int unsigned i = 0; i < v; i++) begin
         if (!ban_mark[i] && (!have || logit_mem[i] > best)) begin
            have = 1;
            best = logit_mem[i];
            idx = i;
         end
      end
      r.tok = idx[15:0];
      r.stat = lost ? STAT_DROPPED : STAT_OK;
      return r;
   endfunction

   function automatic void clear_request();
      vcnt = 0;
      hcnt = 0;
      all_valid = 1;
      lost = 0;
   endfunction

   // absorb one accepted item; returns 1 with the result when it closes a request
   function automatic bit absorb_item(input pick_item_type it, output pick_res_type r);
      bit ok;
      r = '{tok: 16'd0, stat: STAT_OK};
      if (it.kind == 1'b0) begin
         if (vcnt < 65536) begin
            logit_mem[vcnt] = int'(it.lv);
            vcnt++;
         end else lost = 1;
      end else begin
         if (hcnt < 1024) begin
            ok = it.hv && (it.tok <= ID_LIMIT);
            hist_mem[hcnt] = {ok, it.tok};
            if (!ok) all_valid = 0;
            hcnt++;
         end else lost = 1;
      end
      if (!it.last) return 0;
      if (vcnt == 0) r = '{tok: 16'd0, stat: STAT_EMPTY};
      else r = pick_token();
      clear_request();
      return 1;
   endfunction

   task automatic send_item(input pick_item_type it, output bit has, output pick_res_type r);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.kind          <= it.kind;
      req_ch.logit_value   <= it.lv;
      req_ch.history_token <= it.tok;
      req_ch.history_valid <= it.hv;
      req_ch.last          <= it.last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      has = absorb_item(it, r);
   endtask

   task automatic send_checked(input pick_item_type it);
      bit has;
      pick_res_type r;
      send_item(it, has, r);
      if (has) pick_q.push_back(r);
   endtask

   task automatic drain();
      @(posedge clock);
      req_ch.valid <= 1'b0;
      while (pick_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // write enable stays high over back-to-back writes; configure drops it at the end
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_TRACE_STRENGTH: cfg_strength = int'(data);
         CSR_TRACE_WINDOW:   cfg_window   = data[10:0];
         CSR_TRACE_DECAY:    cfg_decay    = data[17:0];
         CSR_REPEAT_PENALTY: cfg_penalty  = data[23:0];
         CSR_NGRAM_SIZE:     cfg_ngram    = data[10:0];
         default: ;
      endcase
   endtask

   function automatic logic [31:0] rand_logit();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3: return $urandom;
         default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      endcase
   endfunction

   // one request; history leans on a short repeating pattern so n-gram matches occur
   task automatic send_request(input int unsigned nv, input int unsigned nh);
      pick_item_type it;
      logic [22:0] pat [4];
      int unsigned plen, left_v, left_h;
      plen = $urandom_range(1, 4);
      for (int i = 0; i < 4; i++) pat[i] = 23'($urandom_range(0, nv + 1));
      left_v = nv;
      left_h = nh;
      if (nv + nh == 0) left_h = 1;
      while (left_v + left_h > 0) begin
         it.lv  = rand_logit();
         it.tok = 23'($urandom);
         it.hv  = 1'($urandom);
         if (left_h == 0 || (left_v != 0 && $urandom_range(0, 1) == 0)) begin
            it.kind = 1'b0;
            left_v--;
         end else begin
            it.kind = 1'b1;
            case ($urandom_range(0, 9))
               0: it.tok = 23'($urandom);
               1: it.tok = 23'($urandom_range(7999998, 8000002));
               2, 3, 4: it.tok = 23'($urandom_range(0, nv + 1));
               default: it.tok = pat[(nh - left_h) % plen];
            endcase
            it.hv = $urandom_range(0, 19) != 0;
            left_h--;
         end
         it.last = (left_v + left_h == 0);
         send_checked(it);
      end
   endtask

   task automatic configure(input int ph);
      logic [31:0] s, w, dc, pn, ng;
      case (ph)
         0: begin s = 0; w = 0; dc = 65536; pn = 65536; ng = 0; end
         1: begin s = 3 * 65536; w = 8; dc = 32768; pn = 0; ng = 2; end
         2: begin s = 32'h8000_0000; w = 1024; dc = 262143; pn = 16777215; ng = 1; end
         3: begin s = 32'h7FFF_FFFF; w = 1; dc = 0; pn = 1; ng = 3; end
         5: begin s = $urandom; w = $urandom_range(0, 1024); dc = 65536; pn = 131072;
            ng = 1024; end
         default: begin
            s = $urandom_range(0, 3) == 0 ? $urandom : 32'($signed($urandom_range(0, 1 << 19))
                - (1 << 18));
            w = $urandom_range(0, 1024);
            dc = $urandom_range(0, 262143);
            pn = $urandom_range(0, 1) ? $urandom_range(0, 16777215) : $urandom_range(0, 200000);
            ng = $urandom_range(0, 4);
         end
      endcase
      csr_write(CSR_TRACE_STRENGTH, s);
      csr_write(CSR_TRACE_WINDOW, w);
      csr_write(CSR_TRACE_DECAY, dc);
      csr_write(CSR_REPEAT_PENALTY, pn);
      csr_write(CSR_NGRAM_SIZE, ng);
      csr_we <= 1'b0;
   endtask

   // result side: random stall bursts outside the quiet phase, compare against oldest expectation
   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready && !reset) begin
         if (pick_q.size() == 0) begin
            $display("%0t unexpected result: expected none, actual tok %h status %h",
                     $time, rsp_ch.chosen_token, rsp_ch.status);
            errors++;
         end else begin
            if (rsp_ch.chosen_token !== pick_q[0].tok) begin
               $display("%0t chosen_token: expected %h actual %h",
                        $time, pick_q[0].tok, rsp_ch.chosen_token);
               errors++;
            end
            if (rsp_ch.status !== pick_q[0].stat) begin
               $display("%0t status: expected %h actual %h",
                        $time, pick_q[0].stat, rsp_ch.status);
               errors++;
            end
            void'(pick_q.pop_front());
         end
      end
      if (quiet) rsp_ch.ready <= 1'b1;
      else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp_ch.ready <= 1'b0;
      end else rsp_ch.ready <= 1'b1;
   end

   pick_row_type rows [13];

   initial begin
      pick_item_type it;
      pick_res_type r;
      bit has;
      req_ch.valid <= 1'b0;
      req_ch.kind <= 1'b0;
      req_ch.logit_value <= '0;
      req_ch.history_token <= '0;
      req_ch.history_valid <= 1'b0;
      req_ch.last <= 1'b0;
      cfg_strength = 0;
      cfg_window = 0;
      cfg_decay = 65536;
      cfg_penalty = 65536;
      cfg_ngram = 0;
      clear_request();

      rows[0]  = '{'{1, 32'h0, 23'd5, 1, 1}, 1, 16'd0, STAT_EMPTY};
      rows[1]  = '{'{0, 32'h8000_0000, 23'd0, 0, 0}, 0, 16'd0, STAT_OK};
      rows[2]  = '{'{0, 32'h7FFF_FFFF, 23'h7FFFFF, 1, 0}, 0, 16'd0, STAT_OK};
      rows[3]  = '{'{0, 32'h0, 23'd0, 0, 1}, 1, 16'd1, STAT_OK};
      rows[4]  = '{'{0, 32'd3, 23'd0, 0, 0}, 0, 16'd0, STAT_OK};
      rows[5]  = '{'{0, 32'd3, 23'd0, 0, 1}, 1, 16'd0, STAT_OK};
      rows[6]  = '{'{0, 32'hFFFF_FFFB, 23'd0, 0, 0}, 0, 16'd0, STAT_OK};
      rows[7]  = '{'{1, 32'h0, 23'd8000000, 1, 0}, 0, 16'd0, STAT_OK};
      rows[8]  = '{'{1, 32'hFFFF_FFFF, 23'd8000001, 1, 0}, 0, 16'd0, STAT_OK};
      rows[9]  = '{'{1, 32'h0, 23'h7FFFFF, 0, 0}, 0, 16'd0, STAT_OK};
      rows[10] = '{'{1, 32'h0, 23'd0, 1, 0}, 0, 16'd0, STAT_OK};
      rows[11] = '{'{0, 32'd7, 23'd0, 0, 1}, 0, 16'd0, STAT_OK};
      rows[12] = '{'{1, 32'h0, 23'd1, 1, 1}, 1, 16'd0, STAT_EMPTY};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         send_item(rows[i].it, has, r);
         if (has) pick_q.push_back(rows[i].typed ? '{tok: rows[i].etok, stat: rows[i].estat} : r);
      end
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         configure(ph);
         if (ph == 9) quiet = 1'b1;
         for (int q = 0; q < 4; q++)
            send_request($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 24),
                         $urandom_range(0, 16));
         if (ph == 4) send_request(3, 1026);   // history store overflow
         drain();
      end

      if (errors == 0) $display("logit_penalty_argmax_picker verification clean");
      else $display("logit_penalty_argmax_picker verification failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("logit_penalty_argmax_picker verification failed");
      $finish;
   end
endmodule
